// ===== hw/rtl/kcf_pkg.sv =====
// Shared constants, types and the control program of the keyframe color fader.
package kcf_pkg;

  localparam int unsigned ChannelBitsDefault  = 8;
  localparam int unsigned FractionBitsDefault = 16;

  localparam int unsigned PeriodW   = 16;
  localparam int unsigned DurW      = 24;
  localparam int unsigned ColorW    = 24;
  localparam int unsigned ElapsedW  = 16;
  localparam int unsigned PendW     = 17;
  localparam int unsigned PosSumW   = DurW + 1;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 24;
  localparam int unsigned OutChanW  = 8;
  localparam int unsigned OutPhaseW = 16;
  localparam int unsigned MacSteps  = 6;
  localparam int unsigned MacW      = 3;

  localparam logic [PeriodW-1:0] PeriodReset = 16'd200;
  localparam logic [DurW-1:0]    DurReset    = 24'd10000;
  localparam logic [ColorW-1:0]  FirstReset  = 24'hFF0000;
  localparam logic [ColorW-1:0]  MiddleReset = 24'h00FF00;
  localparam logic [ColorW-1:0]  LastReset   = 24'h0000FF;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegPeriod   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDuration = 3'd1;
  localparam logic [CfgIdxW-1:0] RegFirst    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMiddle   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegLast     = 3'd4;

  typedef logic [3:0] step_t;

  localparam step_t StIdle     = 4'd0;
  localparam step_t StTest     = 4'd1;
  localparam step_t StDivPos   = 4'd2;
  localparam step_t StSavePos  = 4'd3;
  localparam step_t StDivPend  = 4'd4;
  localparam step_t StSavePend = 4'd5;
  localparam step_t StDivPhase = 4'd6;
  localparam step_t StPhase    = 4'd7;
  localparam step_t StMul      = 4'd8;
  localparam step_t StAcc      = 4'd9;
  localparam step_t StEmit     = 4'd10;
  localparam step_t StDone     = 4'd11;

  typedef enum logic [3:0] {
    OpNop,
    OpTake,
    OpTest,
    OpDiv,
    OpSavePos,
    OpSavePend,
    OpPhase,
    OpMul,
    OpAcc,
    OpEmit
  } op_e;

  typedef enum logic [2:0] {
    CondNever,
    CondAlways,
    CondNoBeat,
    CondBelowPeriod,
    CondDivMore,
    CondMacMore,
    CondOutBusy
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t target;
  } ucode_t;

  // Control store: when the condition holds, jump to target, else go to the next step.
  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t w;
    case (step)
      StIdle:     w = '{op: OpTake,     cond: CondNoBeat,      target: StIdle};
      StTest:     w = '{op: OpTest,     cond: CondBelowPeriod, target: StIdle};
      StDivPos:   w = '{op: OpDiv,      cond: CondDivMore,     target: StDivPos};
      StSavePos:  w = '{op: OpSavePos,  cond: CondNever,       target: StIdle};
      StDivPend:  w = '{op: OpDiv,      cond: CondDivMore,     target: StDivPend};
      StSavePend: w = '{op: OpSavePend, cond: CondNever,       target: StIdle};
      StDivPhase: w = '{op: OpDiv,      cond: CondDivMore,     target: StDivPhase};
      StPhase:    w = '{op: OpPhase,    cond: CondNever,       target: StIdle};
      StMul:      w = '{op: OpMul,      cond: CondNever,       target: StIdle};
      StAcc:      w = '{op: OpAcc,      cond: CondMacMore,     target: StMul};
      StEmit:     w = '{op: OpEmit,     cond: CondOutBusy,     target: StEmit};
      StDone:     w = '{op: OpNop,      cond: CondAlways,      target: StIdle};
      default:    w = '{op: OpNop,      cond: CondAlways,      target: StIdle};
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/keyframe_color_fader.sv =====
// Keyframe color fader: timed RGB fade through three keyframe colors, microcoded.
//
// Input channel (in_valid_i/in_ready_o) carries elapsed_ms_i, the milliseconds
// since the previous beat. The time gathers in a pending count; once it reaches
// the frame period, it moves the cycle position on (modulo the cycle duration),
// the pending count keeps its remainder modulo the period, and one output beat
// (red_o, green_o, blue_o, cycle_phase_o) is produced on out_valid_o/out_ready_i.
// Each channel blends two keyframes with a Q0.FRACTION_BITS fraction inside
// the current half of the cycle.
// A beat that produces no frame returns to the first step from the period test. A
// beat that produces a frame runs through the shared one-bit-per-cycle divider
// (position wrap, pending remainder, phase) and the shared multiplier (6 products).
// A new input beat is taken when the control program is back at its first
// step, even while a finished frame still waits at the output register; the
// program holds on its emit step only if that register is still full.
// Reset clears the pending time and the cycle position and loads the register
// defaults (200 ms period, 10000 ms cycle, red, green, blue keyframes).
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at once.
module keyframe_color_fader #(
  parameter int unsigned CHANNEL_BITS  = kcf_pkg::ChannelBitsDefault,
  parameter int unsigned FRACTION_BITS = kcf_pkg::FractionBitsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [kcf_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [kcf_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [kcf_pkg::ElapsedW-1:0]   elapsed_ms_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [kcf_pkg::OutChanW-1:0]   red_o,
  output logic [kcf_pkg::OutChanW-1:0]   green_o,
  output logic [kcf_pkg::OutChanW-1:0]   blue_o,
  output logic [kcf_pkg::OutPhaseW-1:0]  cycle_phase_o
);

  localparam int unsigned CB    = CHANNEL_BITS;
  localparam int unsigned FB    = FRACTION_BITS;
  localparam int unsigned DqW   = (FB > kcf_pkg::PosSumW) ? FB : kcf_pkg::PosSumW;
  localparam int unsigned CntW  = $clog2(DqW + 1);
  localparam int unsigned ProdW = CB + FB + 1;
  localparam int unsigned ExtW  = kcf_pkg::ColorW + 3 * CB;
  localparam int unsigned RemW  = kcf_pkg::DurW;

  // Configuration registers
  logic [kcf_pkg::PeriodW-1:0] period_q;
  logic [kcf_pkg::DurW-1:0]    dur_q;
  logic [kcf_pkg::ColorW-1:0]  first_q, middle_q, last_q;

  // Control
  kcf_pkg::step_t  step_q, step_d;
  kcf_pkg::ucode_t uc;
  logic            out_valid_q, out_valid_d;

  // Block state
  logic [kcf_pkg::PendW-1:0] pend_q, pend_d;
  logic [kcf_pkg::DurW-1:0]  pos_q, pos_d;

  // Datapath scratch
  logic [RemW-1:0]  rem_q, rem_d;
  logic [DqW-1:0]   dq_q, dq_d;
  logic [RemW-1:0]  dvs_q, dvs_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [FB-1:0]    phase_q, phase_d;
  logic [kcf_pkg::MacW-1:0] mac_q, mac_d;
  logic [ProdW-1:0] prod_q, prod_d;
  logic [ProdW-1:0] acc_q, acc_d;
  logic [CB-1:0]    res_q [3];
  logic [CB-1:0]    res_d [3];
  logic [kcf_pkg::OutChanW-1:0]  red_q, red_d, green_q, green_d, blue_q, blue_d;
  logic [kcf_pkg::OutPhaseW-1:0] cphase_q, cphase_d;

  // Combinational helpers
  logic                        in_beat, out_free, cond_hit, below_period;
  logic [kcf_pkg::PeriodW-1:0] period_eff;
  logic [kcf_pkg::DurW-1:0]    dur_eff;
  logic [kcf_pkg::PosSumW-1:0] pos_sum;
  logic [RemW:0]               trial, diff;
  logic                        ge;
  logic                        seg_hi;
  logic [FB-1:0]               frac;
  logic [FB:0]                 weight;
  logic [ExtW-1:0]             ext_a, ext_b;
  logic [CB-1:0]               chan_a, chan_b, operand;
  logic [1:0]                  chan_k;
  logic [ProdW-1:0]            acc_sum;
  logic [CB+kcf_pkg::OutChanW-1:0] red_w, green_w, blue_w;
  logic [FB+kcf_pkg::OutPhaseW-1:0] phase_w;

  assign uc         = kcf_pkg::ucode_rom(step_q);
  assign in_ready_o = (step_q == kcf_pkg::StIdle);
  assign in_beat    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign period_eff   = (period_q == '0) ? kcf_pkg::PeriodW'(1) : period_q;
  assign dur_eff      = (dur_q == '0) ? kcf_pkg::DurW'(1) : dur_q;
  assign below_period = pend_q < {1'b0, period_eff};
  assign pos_sum      = {1'b0, pos_q} + kcf_pkg::PosSumW'(pend_q);

  // Restoring divider step
  assign trial = {rem_q, dq_q[DqW-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  // Segment select and in-segment fraction
  assign seg_hi  = phase_q[FB-1];
  assign frac    = {phase_q[FB-2:0], 1'b0};
  assign ext_a   = {{(3 * CB){1'b0}}, (seg_hi ? middle_q : first_q)};
  assign ext_b   = {{(3 * CB){1'b0}}, (seg_hi ? last_q : middle_q)};
  assign chan_k  = mac_q[2:1];
  assign chan_a  = ext_a[chan_k * CB +: CB];
  assign chan_b  = ext_b[chan_k * CB +: CB];
  assign operand = mac_q[0] ? chan_b : chan_a;
  assign weight  = mac_q[0] ? {1'b0, frac} : ({1'b1, {FB{1'b0}}} - {1'b0, frac});
  assign acc_sum = acc_q + prod_q;

  assign red_w   = {{kcf_pkg::OutChanW{1'b0}}, res_q[2]};
  assign green_w = {{kcf_pkg::OutChanW{1'b0}}, res_q[1]};
  assign blue_w  = {{kcf_pkg::OutChanW{1'b0}}, res_q[0]};
  assign phase_w = {{kcf_pkg::OutPhaseW{1'b0}}, phase_q};

  always_comb begin
    case (uc.cond)
      kcf_pkg::CondNever:       cond_hit = 1'b0;
      kcf_pkg::CondAlways:      cond_hit = 1'b1;
      kcf_pkg::CondNoBeat:      cond_hit = !in_beat;
      kcf_pkg::CondBelowPeriod: cond_hit = below_period;
      kcf_pkg::CondDivMore:     cond_hit = (cnt_q != CntW'(1));
      kcf_pkg::CondMacMore:     cond_hit = (mac_q != kcf_pkg::MacW'(kcf_pkg::MacSteps - 1));
      kcf_pkg::CondOutBusy:     cond_hit = !out_free;
      default:                  cond_hit = 1'b1;
    endcase
    step_d = cond_hit ? uc.target : kcf_pkg::step_t'(step_q + 1'b1);
  end

  always_comb begin
    pend_d      = pend_q;
    pos_d       = pos_q;
    rem_d       = rem_q;
    dq_d        = dq_q;
    dvs_d       = dvs_q;
    cnt_d       = cnt_q;
    phase_d     = phase_q;
    mac_d       = mac_q;
    prod_d      = prod_q;
    acc_d       = acc_q;
    res_d       = res_q;
    red_d       = red_q;
    green_d     = green_q;
    blue_d      = blue_q;
    cphase_d    = cphase_q;
    out_valid_d = out_valid_q && !out_ready_i;

    case (uc.op)
      kcf_pkg::OpTake: begin
        if (in_beat) begin
          pend_d = pend_q + {1'b0, elapsed_ms_i};
        end
      end
      kcf_pkg::OpTest: begin
        // Load the position wrap: (pos + pend) mod duration
        rem_d = '0;
        dq_d  = DqW'(pos_sum) << (DqW - kcf_pkg::PosSumW);
        dvs_d = dur_eff;
        cnt_d = CntW'(kcf_pkg::PosSumW);
      end
      kcf_pkg::OpDiv: begin
        rem_d = ge ? diff[RemW-1:0] : trial[RemW-1:0];
        dq_d  = {dq_q[DqW-2:0], ge};
        cnt_d = cnt_q - 1'b1;
      end
      kcf_pkg::OpSavePos: begin
        pos_d = rem_q;
        rem_d = '0;
        dq_d  = DqW'(pend_q) << (DqW - kcf_pkg::PendW);
        dvs_d = RemW'(period_eff);
        cnt_d = CntW'(kcf_pkg::PendW);
      end
      kcf_pkg::OpSavePend: begin
        // Phase: (pos << FB) / duration; pos is already below the duration
        pend_d = kcf_pkg::PendW'(rem_q);
        rem_d  = pos_q;
        dq_d   = '0;
        dvs_d  = dur_eff;
        cnt_d  = CntW'(FB);
      end
      kcf_pkg::OpPhase: begin
        phase_d = dq_q[FB-1:0];
        mac_d   = '0;
        acc_d   = '0;
      end
      kcf_pkg::OpMul: begin
        prod_d = {{(FB + 1){1'b0}}, operand} * {{CB{1'b0}}, weight};
      end
      kcf_pkg::OpAcc: begin
        mac_d = mac_q + 1'b1;
        if (mac_q[0]) begin
          res_d[chan_k] = acc_sum[FB +: CB];
          acc_d         = '0;
        end else begin
          acc_d = acc_sum;
        end
      end
      kcf_pkg::OpEmit: begin
        if (out_free) begin
          red_d       = red_w[kcf_pkg::OutChanW-1:0];
          green_d     = green_w[kcf_pkg::OutChanW-1:0];
          blue_d      = blue_w[kcf_pkg::OutChanW-1:0];
          cphase_d    = phase_w[kcf_pkg::OutPhaseW-1:0];
          out_valid_d = 1'b1;
        end
      end
      kcf_pkg::OpNop: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= kcf_pkg::PeriodReset;
      dur_q    <= kcf_pkg::DurReset;
      first_q  <= kcf_pkg::FirstReset;
      middle_q <= kcf_pkg::MiddleReset;
      last_q   <= kcf_pkg::LastReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        kcf_pkg::RegPeriod:   period_q <= cfg_wdata_i[kcf_pkg::PeriodW-1:0];
        kcf_pkg::RegDuration: dur_q    <= cfg_wdata_i[kcf_pkg::DurW-1:0];
        kcf_pkg::RegFirst:    first_q  <= cfg_wdata_i[kcf_pkg::ColorW-1:0];
        kcf_pkg::RegMiddle:   middle_q <= cfg_wdata_i[kcf_pkg::ColorW-1:0];
        kcf_pkg::RegLast:     last_q   <= cfg_wdata_i[kcf_pkg::ColorW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= kcf_pkg::StIdle;
      out_valid_q <= 1'b0;
      pend_q      <= '0;
      pos_q       <= '0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
      pos_q       <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    dq_q     <= dq_d;
    dvs_q    <= dvs_d;
    cnt_q    <= cnt_d;
    phase_q  <= phase_d;
    mac_q    <= mac_d;
    prod_q   <= prod_d;
    acc_q    <= acc_d;
    res_q    <= res_d;
    red_q    <= red_d;
    green_q  <= green_d;
    blue_q   <= blue_d;
    cphase_q <= cphase_d;
  end

  assign out_valid_o   = out_valid_q;
  assign red_o         = red_q;
  assign green_o       = green_q;
  assign blue_o        = blue_q;
  assign cycle_phase_o = cphase_q;

  // The partial remainder never reaches the divisor while dividing
  a_rem_below_divisor : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == kcf_pkg::StDivPos || step_q == kcf_pkg::StDivPend ||
     step_q == kcf_pkg::StDivPhase) |-> rem_q < dvs_q)
    else $error("divider remainder not below divisor");

  // An accepted input beat always moves the program to the period test
  a_beat_to_test : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> step_q == kcf_pkg::StTest)
    else $error("input beat did not start the period test");

  // A frame appears at the output only from the emit step
  a_emit_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(step_q) == kcf_pkg::StEmit)
    else $error("output beat raised outside the emit step");

  // The product counter stays within the six blend terms
  a_mac_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == kcf_pkg::StMul || step_q == kcf_pkg::StAcc) |->
      mac_q < kcf_pkg::MacW'(kcf_pkg::MacSteps))
    else $error("blend term counter out of range");

endmodule
